// ----- rtl/isqn_pkg.sv -----
// Shared types, constants and helpers for the Newton integer square root.
// No dependencies; every other file imports this package.
package isqn_pkg;

  localparam int RadW       = 63;
  localparam int RootW      = 32;
  localparam int EstW       = 33;
  localparam int RemW       = 34;
  localparam int QuoW       = 64;
  localparam int NewtonSteps = 4;

  typedef struct packed {
    logic                valid;
    logic                zero;
    logic [RadW-1:0]     v;
    logic [EstW-1:0]     est;
    logic [RemW-1:0]     rem;
    logic [QuoW-1:0]     quo;
  } isqn_stage_t;

  // entry n = floor(2^((63-n)/2)); entry 0 only seen for a zero radicand
  localparam logic [31:0] SEED_TABLE [64] = '{
    32'd0, 32'd2147483648, 32'd1518500249, 32'd1073741824, 32'd759250124,
    32'd536870912, 32'd379625062, 32'd268435456, 32'd189812531, 32'd134217728,
    32'd94906265, 32'd67108864, 32'd47453132, 32'd33554432, 32'd23726566,
    32'd16777216, 32'd11863283, 32'd8388608, 32'd5931641, 32'd4194304,
    32'd2965820, 32'd2097152, 32'd1482910, 32'd1048576, 32'd741455,
    32'd524288, 32'd370727, 32'd262144, 32'd185363, 32'd131072, 32'd92681,
    32'd65536, 32'd46340, 32'd32768, 32'd23170, 32'd16384, 32'd11585,
    32'd8192, 32'd5792, 32'd4096, 32'd2896, 32'd2048, 32'd1448, 32'd1024,
    32'd724, 32'd512, 32'd362, 32'd256, 32'd181, 32'd128, 32'd90, 32'd64,
    32'd45, 32'd32, 32'd22, 32'd16, 32'd11, 32'd8, 32'd5, 32'd4, 32'd2,
    32'd2, 32'd1, 32'd1
  };

  // leading zeros of the radicand as a 64-bit word; zero radicand gives 0
  function automatic logic [5:0] lead_count(logic [RadW-1:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < RadW; i++) begin
      if (v[i]) n = 6'(RadW - i);
    end
    return n;
  endfunction

endpackage

// ----- rtl/isqn_ifs.sv -----
// Valid/ready channel interfaces for the square root block.
// Depends on isqn_pkg for field widths.
interface isqn_in_if import isqn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RadW-1:0] radicand;
  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface isqn_out_if import isqn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RootW-1:0] root;
  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

// ----- rtl/isqn_seed.sv -----
// Seed stage: leading-zero count and table lookup, registered.
// Depends on isqn_pkg.
module isqn_seed import isqn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            din_valid,
  input  logic [RadW-1:0] din_v,
  output isqn_stage_t     dout
);
  isqn_stage_t st_next;
  logic [5:0]  n;

  always_comb begin
    n               = lead_count(din_v);
    st_next.valid   = din_valid;
    st_next.zero    = (din_v == '0);
    st_next.v       = din_v;
    st_next.est     = EstW'(SEED_TABLE[n]);
    st_next.rem     = '0;
    st_next.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= st_next;
    end
  end
endmodule

// ----- rtl/isqn_div_stage.sv -----
// One restoring-division step: one quotient bit of v / est per stage.
// Depends on isqn_pkg.
module isqn_div_stage import isqn_pkg::*; #(
  parameter int Bit = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  isqn_stage_t din,
  output isqn_stage_t dout
);
  isqn_stage_t     st_next;
  logic [QuoW-1:0] dvd;
  logic [RemW-1:0] sh;
  logic [RemW-1:0] dvs;
  logic            ge;

  always_comb begin
    dvd          = {1'b0, din.v};
    sh           = {din.rem[RemW-2:0], dvd[Bit]};
    dvs          = {1'b0, din.est};
    ge           = (sh >= dvs);
    st_next      = din;
    st_next.rem  = ge ? (sh - dvs) : sh;
    st_next.quo[Bit] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= st_next;
    end
  end
endmodule

// ----- rtl/isqn_newton.sv -----
// One Newton step: 64-stage pipelined divider then est = (est + q) / 2.
// Depends on isqn_pkg and isqn_div_stage.
module isqn_newton import isqn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  isqn_stage_t din,
  output isqn_stage_t dout
);
  isqn_stage_t        st [QuoW+1];
  isqn_stage_t        upd_next;
  logic [QuoW:0]      sum;

  assign st[0] = din;

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    isqn_div_stage #(.Bit(QuoW - 1 - k)) u_div (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (st[k]),
      .dout(st[k+1])
    );
  end

  always_comb begin
    sum          = (QuoW+1)'(st[QuoW].est) + (QuoW+1)'(st[QuoW].quo);
    upd_next     = st[QuoW];
    upd_next.est = sum[EstW:1];
    upd_next.rem = '0;
    upd_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= upd_next;
    end
  end
endmodule

// ----- rtl/integer_square_root_newton.sv -----
// Integer square root: table seed plus Newton steps, fully pipelined.
// Input and seed registers lead in; one transfer per cycle unless the output stalls.
// Each step is a 64-stage one-bit-per-stage divider followed by an averaging stage.
// Synchronous active-high reset clears every stage valid; payloads are not reset.
module integer_square_root_newton import isqn_pkg::*; #(
  parameter int Steps = NewtonSteps
) (
  input  logic        clk,
  input  logic        rst,
  isqn_in_if.sink     arg,
  isqn_out_if.source  res
);
  // Global advance: the whole pipe moves unless the output is held by the sink.
  logic            en;
  logic            in_valid;
  logic [RadW-1:0] in_v;
  isqn_stage_t     nst [Steps+1];

  assign en        = !nst[Steps].valid || res.ready;
  assign arg.ready = en;

  // Input register: a transfer lands here, valid travels with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= arg.valid;
      in_v     <= arg.radicand;
    end
  end

  // Leading-zero count and seed lookup.
  isqn_seed u_seed (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .din_valid(in_valid),
    .din_v    (in_v),
    .dout     (nst[0])
  );

  // Newton steps in series; estimate never reaches zero for a non-zero radicand.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    isqn_newton u_newton (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (nst[s]),
      .dout(nst[s+1])
    );
  end

  // Zero radicand answers 0; otherwise the low 32 bits of the last estimate.
  assign res.valid = nst[Steps].valid;
  assign res.root  = nst[Steps].zero ? '0 : nst[Steps].est[RootW-1:0];

  // Pipe may take a transfer exactly when the output is empty or being drained.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    arg.ready == (!res.valid || res.ready))
    else $error("input ready disagrees with output stall");

  // Reset empties the output stage.
  a_rst: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("output valid after reset");

  // A seeded non-zero radicand always starts from a non-zero estimate.
  a_seed: assert property (@(posedge clk) disable iff (rst)
    (nst[0].valid && !nst[0].zero) |-> (nst[0].est != '0))
    else $error("zero seed for non-zero radicand");

  // A held output keeps its value while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.root)))
    else $error("stalled result changed");
endmodule
